FILE: sv/wso_pkg.sv
// Package for the wheel speed odometer: payload structs, register indexes,
// sequencer states and fixed-point constants.
// No dependencies.
package wso_pkg;

    localparam int STAMP_W   = 32;
    localparam int CIRC_W    = 12;
    localparam int PERIOD_W  = 10;
    localparam int TIMEOUT_W = 16;
    localparam int SPEED_W   = 16;
    localparam int DIST_W    = 44;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    // Multiplier: 32-bit operand by 12-bit operand.
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 12;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Elapsed time: 32-bit ticks times 10-bit period.
    localparam int ELAPSED_W = STAMP_W + PERIOD_W;

    // Speed numerator: circumference * 360 fits in 21 bits.
    localparam int NUM_W     = 21;
    localparam int DIV_CNT_W = 5;

    localparam logic [MUL_A_W-1:0]   KMH_FACTOR   = MUL_A_W'(360);
    localparam logic [SPEED_W-1:0]   SPEED_MAX    = '1;
    localparam logic [STAMP_W-1:0]   INTERVAL_MAX = '1;

    localparam logic [CIRC_W-1:0]    CIRC_RESET    = CIRC_W'(2100);
    localparam logic [PERIOD_W-1:0]  PERIOD_RESET  = PERIOD_W'(1);
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(3000);

    localparam logic KIND_PULSE = 1'b0;
    localparam logic KIND_CHECK = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CIRCUMFERENCE = 2'd0,
        REG_TICK_PERIOD   = 2'd1,
        REG_STOP_TIMEOUT  = 2'd2
    } wso_reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ELAPSED,
        ST_UPDATE,
        ST_DIV,
        ST_DIST,
        ST_OUT
    } wso_state_t;

    typedef struct packed {
        logic               kind;
        logic [STAMP_W-1:0] tick_stamp;
    } wso_in_t;

    typedef struct packed {
        logic [SPEED_W-1:0] speed_centi_kmh;
        logic [STAMP_W-1:0] interval_ms;
        logic [STAMP_W-1:0] rotation_count;
        logic [DIST_W-1:0]  distance_mm;
        logic               is_moving;
        logic               just_stopped;
    } wso_out_t;

endpackage

FILE: sv/wheel_speed_odometer_unit.sv
// Wheel speed odometer top level: sequencer, shared 32x12 multiplier and a
// bit-serial restoring divider for the speed quotient.
// Depends on wso_pkg.
//
// Usage:
//   s_valid/s_ready/s_data carry one event request: kind (0 = wheel pulse,
//   1 = status check) and a 32-bit tick stamp. m_valid/m_ready/m_data return
//   exactly one result per request: speed, interval, rotations, distance,
//   moving flag and a stop marker.
//   cfg_we/cfg_index/cfg_data write circumference (0), tick period (1) and
//   stop timeout (2); other indexes are ignored. Write only while idle.
// Sequence:
//   A pulse is accepted in ST_IDLE, then passes ST_ELAPSED (elapsed multiply),
//   ST_UPDATE (update and numerator multiply), ST_DIV (restoring divider, one
//   step per bit of the 21-bit numerator), ST_DIST (distance multiply) and
//   ST_OUT (output load). A check or a zero-interval pulse skips the divider.
//   s_ready is high only while the sequencer is idle; one request at a time.
// Reset (aresetn low, synchronous): config goes to 2100 mm / 1 ms / 3000 ms,
//   all odometer state to zero, no result pending.
// Stall: a finished result sits in the output register until m_ready; the
//   next request is taken meanwhile and its result waits in ST_OUT if the
//   output register is still full.
module wheel_speed_odometer_unit (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  wso_pkg::wso_in_t                      s_data,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output wso_pkg::wso_out_t                     m_data,
    input  logic                                  cfg_we,
    input  logic [wso_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [wso_pkg::CFG_DATA_W-1:0]        cfg_data
);
    import wso_pkg::*;

    // Sequencer
    wso_state_t state_reg, state_next;

    // Configuration
    logic [CIRC_W-1:0]    circ_reg;
    logic [PERIOD_W-1:0]  period_reg;
    logic [TIMEOUT_W-1:0] timeout_reg;

    // Odometer state
    logic [STAMP_W-1:0] last_tick_reg;
    logic [STAMP_W-1:0] rotations_reg;
    logic               moving_reg;
    logic [SPEED_W-1:0] speed_reg;
    logic [STAMP_W-1:0] interval_reg;

    // Per-request working registers
    logic               kind_reg;
    logic [STAMP_W-1:0] stamp_reg;
    logic [ELAPSED_W-1:0] elapsed_reg;
    logic [NUM_W-1:0]   num_reg;
    logic [NUM_W-1:0]   quot_reg;
    logic [STAMP_W-1:0] rem_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [DIST_W-1:0]  dist_reg;
    logic               stopped_reg;

    // Output register
    logic     m_valid_reg;
    wso_out_t out_reg;

    // Shared multiplier
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [MUL_P_W-1:0] mul_p;

    // Divider step
    logic [STAMP_W+1:0] div_diff;
    logic               div_fit;
    logic               div_last;

    // Decisions made in the update cycle
    logic [STAMP_W-1:0] interval_sat;
    logic               stop_hit;

    logic s_fire;
    logic out_free;

    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign mul_p = {{MUL_B_W{1'b0}}, mul_a} * {{MUL_A_W{1'b0}}, mul_b};

    assign div_diff = {1'b0, rem_reg, num_reg[NUM_W-1]} - {2'b00, interval_reg};
    assign div_fit  = !div_diff[STAMP_W+1];
    assign div_last = (div_cnt_reg == DIV_CNT_W'(NUM_W - 1));

    // Interval saturates when the elapsed time leaves 32 bits.
    assign interval_sat = (elapsed_reg[ELAPSED_W-1:STAMP_W] != '0) ?
                          INTERVAL_MAX : elapsed_reg[STAMP_W-1:0];
    assign stop_hit = moving_reg &&
                      (elapsed_reg > {{(ELAPSED_W-TIMEOUT_W){1'b0}}, timeout_reg});

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_ELAPSED;
            end
            ST_ELAPSED: state_next = ST_UPDATE;
            ST_UPDATE: begin
                if (kind_reg == KIND_PULSE && interval_sat != '0) state_next = ST_DIV;
                else                                              state_next = ST_DIST;
            end
            ST_DIV: begin
                if (div_last) state_next = ST_DIST;
            end
            ST_DIST: state_next = ST_OUT;
            ST_OUT: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs: handshake and multiplier operand select
    always_comb begin
        s_ready = 1'b0;
        mul_a   = '0;
        mul_b   = '0;
        unique case (state_reg)
            ST_IDLE: s_ready = 1'b1;
            ST_ELAPSED: begin
                mul_a = stamp_reg - last_tick_reg;
                mul_b = MUL_B_W'(period_reg);
            end
            ST_UPDATE: begin
                mul_a = KMH_FACTOR;
                mul_b = circ_reg;
            end
            ST_DIST: begin
                mul_a = rotations_reg;
                mul_b = circ_reg;
            end
            ST_DIV, ST_OUT: begin
                mul_a = '0;
                mul_b = '0;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Control and architectural state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            circ_reg      <= CIRC_RESET;
            period_reg    <= PERIOD_RESET;
            timeout_reg   <= TIMEOUT_RESET;
            last_tick_reg <= '0;
            rotations_reg <= '0;
            moving_reg    <= 1'b0;
            speed_reg     <= '0;
            interval_reg  <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_we) begin
                unique case (cfg_index)
                    REG_CIRCUMFERENCE: circ_reg    <= cfg_data[CIRC_W-1:0];
                    REG_TICK_PERIOD:   period_reg  <= cfg_data[PERIOD_W-1:0];
                    REG_STOP_TIMEOUT:  timeout_reg <= cfg_data[TIMEOUT_W-1:0];
                    default: ;
                endcase
            end

            if (state_reg == ST_UPDATE) begin
                if (kind_reg == KIND_PULSE) begin
                    moving_reg    <= 1'b1;
                    rotations_reg <= rotations_reg + STAMP_W'(1);
                    interval_reg  <= interval_sat;
                    last_tick_reg <= stamp_reg;
                    if (interval_sat == '0) speed_reg <= SPEED_MAX;
                end else if (stop_hit) begin
                    moving_reg   <= 1'b0;
                    speed_reg    <= '0;
                    interval_reg <= '0;
                end
            end

            // Quotient complete: saturate to 16 bits
            if (state_reg == ST_DIV && div_last) begin
                if (quot_reg[NUM_W-2:SPEED_W-1] != '0) speed_reg <= SPEED_MAX;
                else speed_reg <= {quot_reg[SPEED_W-2:0], div_fit};
            end

            if (state_reg == ST_OUT && out_free) m_valid_reg <= 1'b1;
            else if (m_ready)                    m_valid_reg <= 1'b0;
        end
    end

    // Datapath working registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            kind_reg  <= s_data.kind;
            stamp_reg <= s_data.tick_stamp;
        end
        if (state_reg == ST_ELAPSED) elapsed_reg <= mul_p[ELAPSED_W-1:0];
        if (state_reg == ST_UPDATE) begin
            num_reg     <= mul_p[NUM_W-1:0];
            rem_reg     <= '0;
            quot_reg    <= '0;
            div_cnt_reg <= '0;
            stopped_reg <= (kind_reg == KIND_CHECK) && stop_hit;
        end
        if (state_reg == ST_DIV) begin
            num_reg     <= {num_reg[NUM_W-2:0], 1'b0};
            quot_reg    <= {quot_reg[NUM_W-2:0], div_fit};
            rem_reg     <= div_fit ? div_diff[STAMP_W-1:0]
                                   : {rem_reg[STAMP_W-2:0], num_reg[NUM_W-1]};
            div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
        end
        if (state_reg == ST_DIST) dist_reg <= mul_p[DIST_W-1:0];
        if (state_reg == ST_OUT && out_free) begin
            out_reg.speed_centi_kmh <= speed_reg;
            out_reg.interval_ms     <= interval_reg;
            out_reg.rotation_count  <= rotations_reg;
            out_reg.distance_mm     <= dist_reg;
            out_reg.is_moving       <= moving_reg;
            out_reg.just_stopped    <= stopped_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule
